### hdl/pst_pkg.sv
`default_nettype none

package pst_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int TIME_BITS  = 32;
    localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    // Compare width for the slot field against a cell position.
    localparam int CMP_BITS   = (SLOT_BITS > 6) ? SLOT_BITS : 6;

    localparam int IN_DATA_BITS  = 72;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 48;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [15:0] STALE_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] PEAK_HYST_RESET     = 16'd41;
    localparam logic [5:0]  COUNT_MAX           = 6'h3F;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STALE_TIMEOUT = 1'b0,
        REG_PEAK_HYST     = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_ALLOC  = 3'd0,
        KIND_PROG   = 3'd1,
        KIND_GAIN   = 3'd2,
        KIND_BOTH   = 3'd3,
        KIND_REMOVE = 3'd4
    } kind_t;

    typedef logic [TIME_BITS-1:0] tstamp_t;
    typedef logic [SLOT_BITS-1:0] pos_t;

    // Command travelling down the row of slot cells, with its running results.
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [5:0]  slot;
        logic [15:0] gain;
        logic [15:0] prog;
        tstamp_t     now;
        pos_t        pos;
        logic        alloc_open;
        pos_t        alloc_idx;
        logic [5:0]  removed;
        logic [15:0] peak;
        logic        first_seen;
        logic [15:0] first_prog;
    } pkt_t;

    function automatic logic [15:0] sat_progress(input logic [17:0] raw);
        logic [15:0] res;
        if (raw[17])
            res = 16'h0000;
        else if (raw[16])
            res = 16'hFFFF;
        else
            res = raw[15:0];
        return res;
    endfunction

    function automatic tstamp_t to_tstamp(input logic [31:0] raw);
        logic [63:0] wide;
        wide = 64'(raw);
        return wide[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/pst_cell.sv
`default_nettype none

module pst_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  wire [15:0]       stale_timeout,
    input  pst_pkg::pkt_t    pkt_in,
    output pst_pkg::pkt_t    pkt_out
);
    import pst_pkg::*;

    logic        active_reg, active_next;
    logic [15:0] prog_reg, prog_next;
    logic [15:0] gain_reg, gain_next;
    tstamp_t     seen_reg, seen_next;
    pkt_t        pkt_reg, pkt_next;

    logic    hit;
    logic    sweep_on;
    tstamp_t age;

    always_comb
    begin
        active_next = active_reg;
        prog_next   = prog_reg;
        gain_next   = gain_reg;
        seen_next   = seen_reg;
        pkt_next    = pkt_in;
        pkt_next.pos = pkt_in.pos + SLOT_BITS'(1);
        hit      = (CMP_BITS'(pkt_in.slot) == CMP_BITS'(pkt_in.pos));
        sweep_on = 1'b0;
        age      = '0;

        if (pkt_in.valid)
        begin
            case (pkt_in.kind)
                KIND_ALLOC:
                begin
                    sweep_on = 1'b1;
                    if (pkt_in.alloc_open && !active_reg)
                    begin
                        active_next         = 1'b1;
                        prog_next           = pkt_in.prog;
                        seen_next           = pkt_in.now;
                        pkt_next.alloc_open = 1'b0;
                        pkt_next.alloc_idx  = pkt_in.pos;
                    end
                end
                KIND_PROG, KIND_GAIN, KIND_BOTH:
                begin
                    if (hit)
                    begin
                        if (pkt_in.kind != KIND_GAIN)
                            prog_next = pkt_in.prog;
                        if (pkt_in.kind != KIND_PROG)
                            gain_next = pkt_in.gain;
                        seen_next = pkt_in.now;
                    end
                end
                KIND_REMOVE:
                begin
                    sweep_on = 1'b1;
                    if (hit)
                    begin
                        active_next = 1'b0;
                        prog_next   = '0;
                        gain_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase

            // On an allocate or remove sweep, free this slot when it went too long without an update.
            age = pkt_in.now - seen_next;
            if (sweep_on && active_next && (age > tstamp_t'(stale_timeout)))
            begin
                active_next = 1'b0;
                prog_next   = '0;
                gain_next   = '0;
                if (pkt_in.removed != COUNT_MAX)
                    pkt_next.removed = pkt_in.removed + 6'd1;
            end

            if (gain_next > pkt_in.peak)
                pkt_next.peak = gain_next;
            if (!pkt_in.first_seen && active_next)
            begin
                pkt_next.first_seen = 1'b1;
                pkt_next.first_prog = prog_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            prog_reg   <= '0;
            gain_reg   <= '0;
            seen_reg   <= '0;
            pkt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            prog_reg   <= prog_next;
            gain_reg   <= gain_next;
            seen_reg   <= seen_next;
            pkt_reg    <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

`default_nettype wire

### hdl/playhead_slot_table.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tuser kind, s_tdata slot/gain/progress/now_ms
// m_*       out        m_tvalid / m_tready  m_tdata slot_index .. any_active
// cfg_*     in         cfg_we               cfg_index, cfg_data
//
// An item passes from input transfer to result through an entry register, then
// the row of slot cells, which the command walks one cell per cycle, then a tail stage
// and the output register. A new item is taken once the previous one has left the
// tail stage, so a result may still wait in the output register.
// Reset clears all slots, the held peak and the registers to their defaults.
// A stalled output holds its result; the row keeps its state meanwhile.
module playhead_slot_table (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // s_tuser: kind[2:0]
    input  wire [pst_pkg::IN_USER_BITS-1:0]     s_tuser,
    // s_tdata: slot[5:0], gain[21:6], progress[39:22], now_ms[71:40]
    input  wire [pst_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // m_tdata: slot_index[4:0], table_full[5], stale_removed[11:6],
    //          peak_gain[27:12], first_progress[43:28], any_active[44], zero pad
    output logic [pst_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    input  wire                                 cfg_we,
    input  wire [pst_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire [pst_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import pst_pkg::*;

    logic [15:0] timeout_reg, timeout_next;
    logic [15:0] hyst_reg, hyst_next;
    logic [15:0] held_peak_reg, held_peak_next;
    logic        busy_reg, busy_next;
    pkt_t        entry_reg, entry_next;
    pkt_t        tail_reg, tail_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;

    pkt_t        pkt_chain [SLOT_COUNT+1];
    logic [SLOT_COUNT:0] chain_valid;

    logic        in_xfer;
    logic        tail_move;
    logic [15:0] peak_diff;
    logic        table_full;
    logic [4:0]  slot_index;

    assign in_xfer   = s_tvalid && s_tready;
    assign tail_move = tail_reg.valid && (!out_valid_reg || m_tready);
    assign s_tready  = !busy_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration writes: decode the register index.
    always_comb
    begin
        timeout_next = timeout_reg;
        hyst_next    = hyst_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_STALE_TIMEOUT: timeout_next = cfg_data;
                REG_PEAK_HYST:     hyst_next    = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Build the command that enters the row; the allocate search starts open.
    always_comb
    begin
        entry_next            = '0;
        entry_next.valid      = in_xfer;
        entry_next.kind       = kind_t'(s_tuser);
        entry_next.slot       = s_tdata[5:0];
        entry_next.gain       = s_tdata[21:6];
        entry_next.prog       = sat_progress(s_tdata[39:22]);
        entry_next.now        = to_tstamp(s_tdata[71:40]);
        entry_next.alloc_open = 1'b1;
    end

    assign pkt_chain[0] = entry_reg;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        pst_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .stale_timeout (timeout_reg),
            .pkt_in        (pkt_chain[i]),
            .pkt_out       (pkt_chain[i+1])
        );
    end

    for (genvar i = 0; i <= SLOT_COUNT; i++)
    begin : g_valid
        assign chain_valid[i] = pkt_chain[i].valid;
    end

    // Catch the command at the end of the row and hold it until the output frees.
    always_comb
    begin
        tail_next = tail_reg;
        if (pkt_chain[SLOT_COUNT].valid)
            tail_next = pkt_chain[SLOT_COUNT];
        else if (tail_move)
            tail_next.valid = 1'b0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_xfer)
            busy_next = 1'b1;
        else if (tail_move)
            busy_next = 1'b0;
    end

    // Held peak follows the maximum only past the hysteresis band.
    always_comb
    begin
        held_peak_next = held_peak_reg;
        peak_diff = (held_peak_reg > tail_reg.peak) ? (held_peak_reg - tail_reg.peak)
                                                    : (tail_reg.peak - held_peak_reg);
        if (tail_move && (peak_diff > hyst_reg))
            held_peak_next = tail_reg.peak;
    end

    always_comb
    begin
        table_full = (tail_reg.kind == KIND_ALLOC) && tail_reg.alloc_open;
        if (tail_reg.kind == KIND_ALLOC)
            slot_index = 5'(tail_reg.alloc_idx);
        else
            slot_index = tail_reg.slot[4:0];

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (tail_move)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, tail_reg.first_seen, tail_reg.first_prog,
                              held_peak_next, tail_reg.removed, table_full, slot_index};
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= STALE_TIMEOUT_RESET;
            hyst_reg      <= PEAK_HYST_RESET;
            held_peak_reg <= '0;
            busy_reg      <= 1'b0;
            entry_reg     <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            hyst_reg      <= hyst_next;
            held_peak_reg <= held_peak_next;
            busy_reg      <= busy_next;
            entry_reg     <= entry_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // Only one command may be in the row or the tail at a time.
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tail_reg.valid, chain_valid}))
        else $error("more than one command in flight");

    // A new transfer never lands while a previous command still sits in the tail.
    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !tail_reg.valid)
        else $error("input taken while tail stage holds a command");

    // When idle, the row and tail are empty.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (chain_valid == '0) && !tail_reg.valid)
        else $error("command in flight while idle");

    // Moving the tail to the output ends the item.
    a_tail_done: assert property (@(posedge clk) disable iff (!rst_n)
        tail_move |=> !busy_reg && m_tvalid)
        else $error("busy not released after result");
`endif

endmodule

`default_nettype wire
